// ===== hw/rtl/crcsbc_pkg.sv =====
`timescale 1ns / 1ps
package crcsbc_pkg;

	localparam int MAX_BYTES = 32;
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);
	localparam int ADDR_W    = $clog2(MAX_BYTES);
	localparam int LIM_W     = 9;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DATA = 2'd1,
		ST_CRC  = 2'd2,
		ST_BAD  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		W8  = 2'd0,
		W16 = 2'd1,
		W32 = 2'd2,
		W64 = 2'd3
	} crc_width_t;

	typedef enum logic {
		REG_WIDTH_MODE   = 1'b0,
		REG_SEARCH_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_CALC,
		S_CHECK,
		S_SEARCH,
		S_TEST,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        end_of_message;
		logic [63:0] received_crc;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        final_out;
		status_t     status;
		logic [63:0] fixed_crc;
		logic [7:0]  flip_position;
	} out_item_t;

	typedef struct packed {
		logic    load;
		logic    pass_start;
		logic    flip_en;
		logic    latch_syn;
		logic    cand_clr;
		logic    cand_inc;
		logic    set_status;
		status_t status_val;
		logic    emit_init;
		logic    emit_ld;
		logic    msg_done;
	} cmd_t;

	typedef struct packed {
		logic pass_done;
		logic crc_match;
		logic last_cand;
		logic syn_onehot;
		logic last_byte;
		logic out_free;
	} sts_t;

	// polynomial left-aligned in a 64-bit word
	function automatic logic [63:0] poly_al(crc_width_t m);
		logic [63:0] p;
		unique case (m)
			W8:  p = {8'hD5, 56'h0};
			W16: p = {16'h8005, 48'h0};
			W32: p = {32'h741B_8CD7, 32'h0};
			W64: p = 64'h42F0_E1EB_A9EA_3693;
			default: p = 64'h0;
		endcase
		return p;
	endfunction

	function automatic logic [5:0] align_shift(crc_width_t m);
		logic [5:0] s;
		unique case (m)
			W8:  s = 6'd56;
			W16: s = 6'd48;
			W32: s = 6'd32;
			W64: s = 6'd0;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

	// one byte, MSB first, on a left-aligned CRC
	function automatic logic [63:0] crc_byte_al(logic [63:0] c, logic [7:0] b,
			logic [63:0] p);
		logic [63:0] r;
		r = c ^ {b, 56'h0};
		for (int k = 0; k < 8; k++) begin
			r = r[63] ? ((r << 1) ^ p) : (r << 1);
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/crcsbc_ram.sv =====
`timescale 1ns / 1ps
module crcsbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/crcsbc_ctrl.sv =====
`timescale 1ns / 1ps
module crcsbc_ctrl import crcsbc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_eom,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid && in_eom) state_d = S_CALC;
			end
			S_CALC: begin
				if (sts.pass_done) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = sts.crc_match ? S_EMIT_RD : S_SEARCH;
			end
			S_SEARCH: begin
				if (sts.pass_done) state_d = S_TEST;
			end
			S_TEST: begin
				if (sts.crc_match || sts.last_cand) state_d = S_EMIT_RD;
				else state_d = S_SEARCH;
			end
			S_EMIT_RD: begin
				if (sts.out_free) state_d = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				state_d = sts.last_byte ? S_LOAD : S_EMIT_RD;
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.status_val = ST_OK;
		in_stall = (state_q != S_LOAD);
		unique case (state_q)
			S_LOAD: begin
				cmd.load = in_valid;
				cmd.pass_start = in_valid && in_eom;
			end
			S_CALC: ;
			S_CHECK: begin
				if (sts.crc_match) begin
					cmd.set_status = 1'b1;
					cmd.status_val = ST_OK;
					cmd.emit_init = 1'b1;
				end else begin
					cmd.latch_syn = 1'b1;
					cmd.cand_clr = 1'b1;
					cmd.pass_start = 1'b1;
					cmd.flip_en = 1'b1;
				end
			end
			S_SEARCH: ;
			S_TEST: begin
				if (sts.crc_match) begin
					cmd.set_status = 1'b1;
					cmd.status_val = ST_DATA;
					cmd.emit_init = 1'b1;
				end else if (sts.last_cand) begin
					cmd.set_status = 1'b1;
					cmd.status_val = sts.syn_onehot ? ST_CRC : ST_BAD;
					cmd.emit_init = 1'b1;
				end else begin
					cmd.cand_inc = 1'b1;
					cmd.pass_start = 1'b1;
					cmd.flip_en = 1'b1;
				end
			end
			S_EMIT_RD: ;
			S_EMIT_LD: begin
				cmd.emit_ld = 1'b1;
				cmd.msg_done = sts.last_byte;
			end
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/crcsbc_dp.sv =====
`timescale 1ns / 1ps
module crcsbc_dp import crcsbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_item,
	input  logic       cfg_we,
	input  reg_idx_t   cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       out_stall,
	output logic       out_valid,
	output out_item_t  out_item,
	input  cmd_t       cmd,
	output sts_t       sts
);

	crc_width_t       wmode_q;
	logic [LIM_W-1:0] limit_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ptr_q;
	logic             run_q;
	logic             flip_q;
	logic             vld_s1;
	logic             last_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic [63:0]      crc_q;
	logic [63:0]      rx_q;
	logic [63:0]      syn_q;
	logic [7:0]       cand_q;
	status_t          status_q;
	logic             out_vld_q;
	out_item_t        out_q;

	logic [7:0]       rdata;
	logic             wr_en;
	logic [CNT_W-1:0] n_last;
	logic [LIM_W-1:0] total, lim_eff;
	logic [7:0]       fmask_pass, fmask_out;
	logic [5:0]       shift, syn_idx;
	logic [63:0]      fixed_al;
	logic [7:0]       pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wmode_q <= W16;
			limit_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH_MODE:   wmode_q <= crc_width_t'(cfg_data[1:0]);
				REG_SEARCH_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign wr_en = cmd.load && (cnt_q < CNT_W'(MAX_BYTES));

	crcsbc_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (in_item.data_byte),
		.raddr (ptr_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	assign n_last  = cnt_q - CNT_W'(1);
	assign total   = {cnt_q, 3'b000};
	assign lim_eff = (limit_q == '0 || limit_q > total) ? total : limit_q;
	assign shift   = align_shift(wmode_q);

	assign fmask_pass = (flip_q && idx_s1 == cand_q[7:3]) ? (8'd1 << cand_q[2:0]) : 8'd0;
	assign fmask_out  = (status_q == ST_DATA && ptr_q[ADDR_W-1:0] == cand_q[7:3])
	                    ? (8'd1 << cand_q[2:0]) : 8'd0;

	always_comb begin
		syn_idx = '0;
		for (int k = 0; k < 64; k++) begin
			if (syn_q[k]) syn_idx = syn_idx | 6'(k);
		end
	end

	assign fixed_al = (status_q == ST_CRC) ? (rx_q ^ syn_q) : rx_q;

	always_comb begin
		unique case (status_q)
			ST_DATA: pos = cand_q;
			ST_CRC:  pos = {2'b00, syn_idx - shift};
			default: pos = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ptr_q     <= '0;
			run_q     <= 1'b0;
			vld_s1    <= 1'b0;
			last_s1   <= 1'b0;
			out_vld_q <= 1'b0;
			flip_q    <= 1'b0;
			status_q  <= ST_OK;
		end else begin
			if (cmd.msg_done) cnt_q <= '0;
			else if (wr_en) cnt_q <= cnt_q + CNT_W'(1);

			if (cmd.pass_start || cmd.emit_init) begin
				ptr_q <= '0;
			end else if (run_q || cmd.emit_ld) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end

			if (cmd.pass_start) begin
				run_q  <= 1'b1;
				flip_q <= cmd.flip_en;
			end else if (run_q && ptr_q == n_last) begin
				run_q <= 1'b0;
			end
			vld_s1  <= run_q;
			last_s1 <= run_q && (ptr_q == n_last);

			if (cmd.set_status) status_q <= cmd.status_val;

			if (cmd.emit_ld) out_vld_q <= 1'b1;
			else if (!out_stall) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q[ADDR_W-1:0];
		if (cmd.pass_start) crc_q <= '0;
		else if (vld_s1) crc_q <= crc_byte_al(crc_q, rdata ^ fmask_pass, poly_al(wmode_q));
		if (cmd.load && in_item.end_of_message) rx_q <= in_item.received_crc << shift;
		if (cmd.latch_syn) syn_q <= crc_q ^ rx_q;
		if (cmd.cand_clr) cand_q <= '0;
		else if (cmd.cand_inc) cand_q <= cand_q + 8'd1;
		if (cmd.emit_ld) begin
			out_q.out_byte      <= rdata ^ fmask_out;
			out_q.final_out     <= (ptr_q == n_last);
			out_q.status        <= status_q;
			out_q.fixed_crc     <= fixed_al >> shift;
			out_q.flip_position <= pos;
		end
	end

	assign sts.pass_done  = vld_s1 && last_s1;
	assign sts.crc_match  = (crc_q == rx_q);
	assign sts.last_cand  = ({1'b0, cand_q} + 9'd1) == lim_eff;
	assign sts.syn_onehot = (syn_q != '0) && ((syn_q & (syn_q - 64'd1)) == '0);
	assign sts.last_byte  = (ptr_q == n_last);
	assign sts.out_free   = !out_vld_q || !out_stall;

	assign out_valid = out_vld_q;
	assign out_item  = out_q;

endmodule

// ===== hw/rtl/crc_check_single_bit_correct.sv =====
`timescale 1ns / 1ps
// Load: one byte per cycle while idle; in_stall rises after the final byte.
// Check: recompute the CRC over the n stored bytes (one store read port).
// Search: one store pass per trial bit flip, up to 8n trials; each byte is then emitted.
// The trial search dominates the worst case, set by the single store read port.
// Reset (arst_n low, async): idle, empty message, width 16 bit, search limit all bits.
module crc_check_single_bit_correct import crcsbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	input  logic       cfg_we,
	input  reg_idx_t   cfg_index,
	input  logic [8:0] cfg_data
);

	// command / status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// Sequencer: load, recompute, trial flips in bit order, then emit the run.
	crcsbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_eom   (in_item.end_of_message),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: byte store, left-aligned CRC engine, syndrome, output register.
	// A pending output transaction does not block loading of the next message.
	crcsbc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== hw/rtl/crcsbc_chk.sv =====
`timescale 1ns / 1ps
module crcsbc_chk import crcsbc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output transaction changed");

	a_busy_after_eom: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.end_of_message |=> in_stall)
		else $error("input taken right after final byte");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == ST_OK || out_item.status == ST_BAD)
		|-> out_item.flip_position == 8'd0)
		else $error("flip position set without a fix");

	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_item.final_out |=> !out_valid)
		else $error("back-to-back output within a run");

endmodule

bind crc_check_single_bit_correct crcsbc_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// ===== bench/crc_check_single_bit_correct_tb.sv =====
`timescale 1ns / 1ps
module crc_check_single_bit_correct_tb;
	import crcsbc_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_item;
	logic       cfg_we;
	reg_idx_t   cfg_index;
	logic [8:0] cfg_data;

	crc_check_single_bit_correct uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam int WATCHDOG_LIMIT = 200000;

	// Predictor state: a mirror of the block's registers and message buffer.
	crc_width_t mdl_width;
	logic [8:0] mdl_limit;
	logic [7:0] mdl_msg [MAX_BYTES];
	int         mdl_count;

	out_item_t  expected_bytes[$];
	int         error_count;
	int         idle_cycles;
	logic       timed_out;

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic int width_of(crc_width_t m);
		return 8 << int'(m);
	endfunction

	function automatic logic [63:0] mask_of(crc_width_t m);
		return (m == W64) ? '1 : ((64'd1 << width_of(m)) - 64'd1);
	endfunction

	function automatic logic [63:0] poly_of(crc_width_t m);
		case (m)
			W8:      return 64'hD5;
			W16:     return 64'h8005;
			W32:     return 64'h741B_8CD7;
			default: return 64'h42F0_E1EB_A9EA_3693;
		endcase
	endfunction

	// Right-aligned MSB-first CRC over the first n buffered bytes.
	function automatic logic [63:0] msg_crc(int n, crc_width_t m);
		logic [63:0] c;
		logic [63:0] top;
		int w;
		w = width_of(m);
		top = 64'd1 << (w - 1);
		c = '0;
		for (int i = 0; i < n; i++) begin
			c ^= {56'd0, mdl_msg[i]} << (w - 8);
			for (int k = 0; k < 8; k++)
				c = (c & top) ? ((c << 1) ^ poly_of(m)) : (c << 1);
			c &= mask_of(m);
		end
		return c;
	endfunction

	// Store one byte; on end of message, search for a repair and queue the run.
	task automatic predict_byte(in_item_t it);
		logic [63:0] rx, calc, fixed;
		status_t st;
		int pos, lim, n;
		logic [7:0] f;
		if (mdl_count < MAX_BYTES) begin
			mdl_msg[mdl_count] = it.data_byte;
			mdl_count++;
		end
		if (!it.end_of_message)
			return;
		n = mdl_count;
		rx = it.received_crc & mask_of(mdl_width);
		calc = msg_crc(n, mdl_width);
		fixed = rx;
		st = ST_OK;
		pos = 0;
		if (calc != rx) begin
			st = ST_BAD;
			lim = mdl_limit;
			if (lim == 0 || lim > 8 * n)
				lim = 8 * n;
			for (int i = 0; i < lim; i++) begin
				f = 8'd1 << (i % 8);
				mdl_msg[i / 8] ^= f;
				if (msg_crc(n, mdl_width) == rx) begin
					st = ST_DATA;
					pos = i;
					break;
				end
				mdl_msg[i / 8] ^= f;
			end
			if (st == ST_BAD) begin
				for (int i = 0; i < width_of(mdl_width); i++) begin
					if ((calc ^ rx ^ (64'd1 << i)) == 0) begin
						st = ST_CRC;
						fixed = rx ^ (64'd1 << i);
						pos = i;
						break;
					end
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			out_item_t e;
			e.out_byte = mdl_msg[i];
			e.final_out = (i + 1 == n);
			e.status = st;
			e.fixed_crc = fixed;
			e.flip_position = pos[7:0];
			expected_bytes.push_back(e);
		end
		mdl_count = 0;
	endtask

	// Offer one byte after a random gap and wait for the transaction.
	task automatic send_byte(logic [7:0] b, logic eom, logic [63:0] rx);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{data_byte: b, end_of_message: eom, received_crc: rx};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_byte('{data_byte: b, end_of_message: eom, received_crc: rx});
		// block is busy after the final byte; drop valid before anything else
		if (eom) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic write_reg(reg_idx_t idx, logic [8:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH_MODE)
			mdl_width = crc_width_t'(val[1:0]);
		else
			mdl_limit = val;
		@(posedge clk);
	endtask

	// Wait until every queued result has drained plus a settling margin.
	task automatic wait_drained();
		while (expected_bytes.size() != 0 && !timed_out)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Build a message with a known-good CRC, then optionally corrupt it.
	// kind: 0 clean, 1 data flip, 2 CRC flip, 3 two flips, 4 random CRC
	task automatic send_message(int len, int kind, logic [63:0] junk_hi);
		logic [7:0] buf_b [64];
		logic [63:0] rx;
		int w, p;
		w = width_of(mdl_width);
		for (int i = 0; i < len; i++)
			buf_b[i] = $urandom_range(0, 255);
		for (int i = 0; i < len && i < MAX_BYTES; i++)
			mdl_msg[i] = buf_b[i];
		rx = msg_crc((len < MAX_BYTES) ? len : MAX_BYTES, mdl_width);
		case (kind)
			1: begin
				p = $urandom_range(0, 8 * len - 1);
				buf_b[p / 8] ^= 8'd1 << (p % 8);
			end
			2: rx ^= 64'd1 << $urandom_range(0, w - 1);
			3: begin
				p = $urandom_range(0, 8 * len - 1);
				buf_b[p / 8] ^= 8'd1 << (p % 8);
				rx ^= 64'd1 << $urandom_range(0, w - 1);
			end
			4: rx = {$urandom, $urandom};
			default: ;
		endcase
		rx |= junk_hi & ~mask_of(mdl_width);
		for (int i = 0; i < len; i++)
			send_byte(buf_b[i], i == len - 1, rx);
	endtask

	task automatic test_directed();
		// every width, clean/data/CRC/uncorrectable, full-range garbage above width
		for (int m = 0; m < 4; m++) begin
			write_reg(REG_WIDTH_MODE, 9'(m));
			send_message(1, 0, '1);
			send_message(2, 1, '1);
			send_message(1, 2, 64'h0);
			send_message(3, 3, '1);
			wait_drained();
		end
		// extreme bytes, single-byte message
		send_byte(8'h00, 1'b1, 64'h0);
		send_byte(8'hFF, 1'b1, '1);
		wait_drained();
	endtask

	task automatic test_limits();
		write_reg(REG_WIDTH_MODE, 9'(W16));
		write_reg(REG_SEARCH_LIMIT, 9'd1);
		send_message(2, 1, '0);
		wait_drained();
		write_reg(REG_SEARCH_LIMIT, 9'd511);
		send_message(2, 1, '0);
		wait_drained();
		write_reg(REG_SEARCH_LIMIT, 9'd256);
		send_message(3, 1, '0);
		wait_drained();
		write_reg(REG_SEARCH_LIMIT, 9'd0);
	endtask

	task automatic test_overlength();
		write_reg(REG_WIDTH_MODE, 9'(W8));
		send_message(MAX_BYTES, 1, '0);
		send_message(MAX_BYTES + 2, 0, '0);
		wait_drained();
	endtask

	task automatic test_width_change();
		// switch width mid-message; check uses width at the final byte
		send_byte(8'h5A, 1'b0, '0);
		in_valid <= 1'b0;
		write_reg(REG_WIDTH_MODE, 9'(W32));
		send_byte(8'hA5, 1'b1, 64'h1234_5678);
		wait_drained();
	endtask

	task automatic test_random();
		int sent;
		int kind;
		sent = 0;
		while (sent < 48 && !timed_out) begin
			write_reg(REG_WIDTH_MODE, 9'($urandom_range(0, 3)));
			write_reg(REG_SEARCH_LIMIT, ($urandom_range(0, 3) == 0) ?
				9'($urandom_range(0, 511)) : 9'd0);
			for (int j = 0; j < 4; j++) begin
				int len;
				len = $urandom_range(1, 6);
				kind = $urandom_range(0, 9);
				if (kind > 4)
					kind = 1;
				send_message(len, kind, {$urandom, $urandom});
				sent += len;
			end
			wait_drained();
		end
	endtask

	// Result checker: compare each accepted transaction with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected result byte %h", out_item.out_byte);
				error_count++;
			end else begin
				out_item_t e;
				e = expected_bytes.pop_front();
				if (out_item.out_byte !== e.out_byte) begin
					$error("out_byte exp %h got %h", e.out_byte, out_item.out_byte);
					error_count++;
				end
				if (out_item.final_out !== e.final_out) begin
					$error("final_out exp %b got %b", e.final_out, out_item.final_out);
					error_count++;
				end
				if (out_item.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, out_item.status);
					error_count++;
				end
				if (out_item.fixed_crc !== e.fixed_crc) begin
					$error("fixed_crc exp %h got %h", e.fixed_crc, out_item.fixed_crc);
					error_count++;
				end
				if (out_item.flip_position !== e.flip_position) begin
					$error("flip_position exp %0d got %0d",
						e.flip_position, out_item.flip_position);
					error_count++;
				end
			end
		end
	end

	// Receiver back-pressure: random stall length per transaction, some bursts with none.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (out_valid && !out_stall) begin
			stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: the search may run long with nothing accepted.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			timed_out = 1'b1;
			$display("crc_check_single_bit_correct_tb failed");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		mdl_width = W16;
		mdl_limit = '0;
		mdl_count = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH_MODE;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_limits();
		test_overlength();
		test_width_change();
		test_random();
		wait_drained();

		if (error_count == 0 && expected_bytes.size() == 0)
			$display("crc_check_single_bit_correct_tb passed");
		else begin
			if (expected_bytes.size() != 0)
				$error("%0d expected result bytes never arrived", expected_bytes.size());
			$display("crc_check_single_bit_correct_tb failed");
		end
		$finish;
	end

endmodule
